// ===== hdl/mtf_pkg.sv =====
package mtf_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 4;
  localparam int COUNT_W    = 5;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    MODE_FRONT = 2'd0,
    MODE_BACK  = 2'd1,
    MODE_MOVE  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Per-request controls broadcast along the chain
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic move_front;
  } cell_ctl_t;

endpackage

// ===== hdl/mtf_cell.sv =====
module mtf_cell (
  input  logic                    clk,
  input  mtf_pkg::cell_ctl_t      ctl,
  input  logic [mtf_pkg::IDX_W-1:0] idx,
  input  logic [mtf_pkg::CNT_W-1:0] occ,
  input  mtf_pkg::value_t         value,
  input  mtf_pkg::value_t         prev_entry,
  input  logic                    hit_in,
  output mtf_pkg::value_t         entry,
  output logic                    hit_out,
  output logic                    first
);
  import mtf_pkg::*;

  logic in_use;
  logic tail;
  logic match;

  assign in_use  = CNT_W'(idx) < occ;
  assign tail    = CNT_W'(idx) == occ;
  assign match   = in_use && (entry == value);
  assign hit_out = hit_in | match;
  assign first   = match & ~hit_in;

  // cells up to and including the first match shift back on a move
  always_ff @(posedge clk) begin
    if (ctl.push_front || (ctl.move_front && !hit_in)) begin
      entry <= prev_entry;
    end else if (ctl.push_back && tail) begin
      entry <= value;
    end
  end

endmodule

// ===== hdl/move_to_front_list.sv =====
// channel | dir | tdata (low bit up)                     | tuser
// s_*     | in  | value[31:0]                            | mode[1:0]
// m_*     | out | found_position[3:0], entry_count[8:4]  | status[1:0]
//
// One request per cycle while the result is not stalled: every cell compares
// against the request value in parallel and the first-match flag ripples down
// the cell chain; the list updates at the accepting edge and the result lands
// in the output register. rst clears the count and the output valid; cell
// contents are not reset. A stalled result holds s_tready low.
module move_to_front_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // found_position[3:0], entry_count[8:4], zero pad
  output logic [1:0]  m_tuser    // status[1:0]
);
  import mtf_pkg::*;

  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] occ_next;
  logic             accept;
  logic             full;
  mode_t            mode;
  value_t           value;
  cell_ctl_t        ctl;
  status_t          status;
  logic [IDX_W-1:0] pos;
  logic             any_hit;

  value_t           entry [LIST_DEPTH];
  logic             hit   [LIST_DEPTH+1];
  logic             first [LIST_DEPTH];

  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;
  assign mode     = mode_t'(s_tuser);
  assign value    = value_t'(s_tdata);
  assign full     = occ == CNT_W'(LIST_DEPTH);
  assign hit[0]   = 1'b0;
  assign any_hit  = hit[LIST_DEPTH];

  genvar g;
  generate
    for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
      mtf_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .idx        (IDX_W'(g)),
        .occ        (occ),
        .value      (value),
        .prev_entry ((g == 0) ? value : entry[(g == 0) ? 0 : g - 1]),
        .hit_in     (hit[g]),
        .entry      (entry[g]),
        .hit_out    (hit[g+1]),
        .first      (first[g])
      );
    end
  endgenerate

  // one-hot first match to index
  always_comb begin
    pos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (first[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  always_comb begin
    ctl      = '0;
    occ_next = occ;
    status   = ST_DONE;
    unique case (mode)
      MODE_FRONT, MODE_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.push_front = accept & (mode == MODE_FRONT);
          ctl.push_back  = accept & (mode == MODE_BACK);
          occ_next       = occ + CNT_W'(1);
        end
      end
      MODE_MOVE: begin
        if (any_hit) begin
          ctl.move_front = accept;
        end else begin
          status = ST_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        occ      <= occ_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= status;
      m_tdata <= {7'd0, COUNT_W'(occ_next),
                  (mode == MODE_MOVE && any_hit) ? POS_W'(pos) : POS_W'(0)};
    end
  end

endmodule
